### rtl/core/tcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, register codes and constants of the template correlation
// detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam int TEMPLATE_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WLEN_W     = 9;
    localparam int THR_W      = 16;
    localparam int GAP_W      = 16;
    localparam int EVT_W      = 32;
    localparam int CORR_FRAC  = 15;
    localparam int CORR_W     = CORR_FRAC + 1;

    localparam logic [WLEN_W-1:0]        WINDOW_LENGTH_RST = 9'd256;
    localparam logic signed [THR_W-1:0]  THRESHOLD_RST     = 16'sd26214;
    localparam logic [GAP_W-1:0]         MIN_GAP_RST       = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_MATCH_THRESH  = 2'd1,
        CFG_MIN_GAP       = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_TEMPLATE = 1'b0,
        OP_SIGNAL   = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_MAC,
        BS_PROD,
        BS_DIFF,
        BS_CHECK,
        BS_MUL,
        BS_ROOT_A,
        BS_ROOT_B,
        BS_DONE
    } t_back_state;

endpackage

`default_nettype wire

### rtl/core/tcd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/tcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_front
// Accepts template and signal samples, writes them to the stores and issues
// a correlation job when both hold a full window.
// ----------------------------------------------------------------------------
module tcd_front import tcd_pkg::*; #(
    parameter int TEMPLATE_MAX  = TEMPLATE_MAX_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int AW    = (TEMPLATE_MAX > 1) ? $clog2(TEMPLATE_MAX) : 1,
    localparam int LEN_W = $clog2(TEMPLATE_MAX + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic                     i_operation,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic [WLEN_W-1:0]        i_window_length,
    input  wire logic                     i_job_take,
    output logic                          o_job_vld,
    output logic [LEN_W-1:0]              o_job_len,
    output logic [AW-1:0]                 o_job_widx,
    output logic [POSITION_BITS-1:0]      o_job_start,
    output logic                          o_t_we,
    output logic [AW-1:0]                 o_t_waddr,
    output logic                          o_w_we,
    output logic [AW-1:0]                 o_w_waddr,
    output logic [SAMPLE_BITS-1:0]        o_wdata
);

    logic [LEN_W-1:0]         r_tfill, n_tfill;
    logic [LEN_W-1:0]         r_wfill, n_wfill;
    logic [AW-1:0]            r_head, n_head;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_job_vld;
    logic [LEN_W-1:0]         r_job_len;
    logic [AW-1:0]            r_job_widx;
    logic [POSITION_BITS-1:0] r_job_start;
    logic [LEN_W-1:0]         eff_len;
    logic [LEN_W:0]           head_ext;
    logic [LEN_W:0]           widx_ext;
    logic                     is_sig;
    logic                     job_new;

    always_comb begin
        if (i_window_length < 9'd2) begin
            eff_len = LEN_W'(2);
        end else if (32'(i_window_length) > TEMPLATE_MAX) begin
            eff_len = LEN_W'(TEMPLATE_MAX);
        end else begin
            eff_len = LEN_W'(i_window_length);
        end
    end

    always_comb begin
        is_sig  = i_accept && (i_operation == OP_SIGNAL);
        n_tfill = r_tfill;
        n_wfill = r_wfill;
        n_head  = r_head;
        n_pos   = r_pos;
        if (i_accept && (i_operation == OP_TEMPLATE) && (32'(r_tfill) < TEMPLATE_MAX)) begin
            n_tfill = r_tfill + LEN_W'(1);
        end
        if (is_sig) begin
            n_head = (r_head == AW'(TEMPLATE_MAX - 1)) ? '0 : r_head + AW'(1);
            n_pos  = r_pos + POSITION_BITS'(1);
            if (32'(r_wfill) < TEMPLATE_MAX) begin
                n_wfill = r_wfill + LEN_W'(1);
            end
        end
        job_new  = is_sig && (r_tfill >= eff_len) && (n_wfill >= eff_len);
        head_ext = (LEN_W+1)'(n_head);
        if (head_ext >= (LEN_W+1)'(eff_len)) begin
            widx_ext = head_ext - (LEN_W+1)'(eff_len);
        end else begin
            widx_ext = head_ext + (LEN_W+1)'(TEMPLATE_MAX) - (LEN_W+1)'(eff_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tfill   <= '0;
            r_wfill   <= '0;
            r_head    <= '0;
            r_pos     <= '0;
            r_job_vld <= 1'b0;
        end else begin
            r_tfill <= n_tfill;
            r_wfill <= n_wfill;
            r_head  <= n_head;
            r_pos   <= n_pos;
            if (job_new) begin
                r_job_vld <= 1'b1;
            end else if (i_job_take) begin
                r_job_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_new) begin
            r_job_len   <= eff_len;
            r_job_widx  <= widx_ext[AW-1:0];
            r_job_start <= n_pos - POSITION_BITS'(eff_len);
        end
    end

    assign o_job_vld   = r_job_vld;
    assign o_job_len   = r_job_len;
    assign o_job_widx  = r_job_widx;
    assign o_job_start = r_job_start;
    assign o_t_we      = i_accept && (i_operation == OP_TEMPLATE) &&
                         (32'(r_tfill) < TEMPLATE_MAX);
    assign o_t_waddr   = r_tfill[AW-1:0];
    assign o_w_we      = is_sig;
    assign o_w_waddr   = r_head;
    assign o_wdata     = i_sample;

endmodule

`default_nettype wire

### rtl/core/tcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_back
// Runs one correlation job: accumulates sums over the window, forms the
// variances, multiplies them out bit-serially, finds the Q1.15 quotient of
// the root bit by bit and applies the threshold and event rules.
// ----------------------------------------------------------------------------
module tcd_back import tcd_pkg::*; #(
    parameter int TEMPLATE_MAX  = TEMPLATE_MAX_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int AW    = (TEMPLATE_MAX > 1) ? $clog2(TEMPLATE_MAX) : 1,
    localparam int LEN_W = $clog2(TEMPLATE_MAX + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic signed [THR_W-1:0]         i_threshold,
    input  wire logic [GAP_W-1:0]                i_min_gap,
    input  wire logic                            i_job_vld,
    output logic                                 o_job_take,
    input  wire logic [LEN_W-1:0]                i_job_len,
    input  wire logic [AW-1:0]                   i_job_widx,
    input  wire logic [POSITION_BITS-1:0]        i_job_start,
    output logic                                 o_busy,
    output logic [AW-1:0]                        o_t_raddr,
    output logic [AW-1:0]                        o_w_raddr,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_t_rdata,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_w_rdata,
    output logic                                 o_res_push,
    input  wire logic                            i_res_full,
    output logic [POSITION_BITS-1:0]             o_window_start,
    output logic signed [CORR_W-1:0]             o_correlation,
    output logic                                 o_above_threshold,
    output logic                                 o_new_event,
    output logic [EVT_W-1:0]                     o_event_count
);

    localparam int SUM_W  = SAMPLE_BITS + LEN_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LEN_W;
    localparam int V_W    = 2 * SAMPLE_BITS + 2 * LEN_W + 1;
    localparam int WW     = 2 * V_W + 2 * CORR_FRAC + 2;
    localparam int STEP_W = $clog2(V_W + 1);
    localparam int BIT_W  = $clog2(CORR_FRAC + 1);
    localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {CORR_FRAC{1'b1}}};
    localparam logic [CORR_W-1:0] CORR_MIN = {1'b1, {CORR_FRAC{1'b0}}};

    t_back_state r_state, n_state;

    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          r_cnt;
    logic [AW-1:0]             r_widx;
    logic [POSITION_BITS-1:0]  r_start;
    logic                      r_rd_vld;
    logic signed [SUM_W-1:0]   r_st, r_sw;
    logic signed [SQ_W-1:0]    r_stt, r_sww, r_stw;
    logic signed [V_W-1:0]     r_tl, r_ts, r_wl, r_ws, r_nl, r_ns;
    logic                      r_flat, r_neg;
    logic [WW-1:0]             r_pa, r_qa, r_prod, r_rsq;
    logic [V_W-1:0]            r_pb, r_qb;
    logic [STEP_W-1:0]         r_step;
    logic [BIT_W-1:0]          r_bit;
    logic [WW-1:0]             r_acc, r_pm, r_s1;
    logic [CORR_W-1:0]         r_m;
    logic [POSITION_BITS-1:0]  r_last;
    logic [EVT_W-1:0]          r_events;

    logic signed [2*SAMPLE_BITS-1:0] tt, ww, tw;
    logic signed [LEN_W:0]           len_s;
    logic [V_W-1:0]                  mag;
    logic [WW-1:0]                   rhs, cand;
    logic [BIT_W:0]                  sh_pm;
    logic [BIT_W:0]                  sh_pr;
    logic signed [CORR_W-1:0]        corr;
    logic                            above, fresh;
    logic [POSITION_BITS-1:0]        match_dist;

    always_comb begin
        tt    = i_t_rdata * i_t_rdata;
        ww    = i_w_rdata * i_w_rdata;
        tw    = i_t_rdata * i_w_rdata;
        len_s = $signed({1'b0, r_len});
        mag   = r_nl[V_W-1] ? $unsigned(-r_nl) : $unsigned(r_nl);
        rhs   = r_rsq << (2 * CORR_FRAC);
        sh_pm = {1'b0, r_bit} + (BIT_W+1)'(1);
        sh_pr = {r_bit, 1'b0};
        cand  = r_s1 + (r_prod << sh_pr);
        if (r_flat) begin
            corr = '0;
        end else if (r_neg) begin
            corr = r_m[CORR_W-1] ? $signed(CORR_MIN) : $signed(~r_m + CORR_W'(1));
        end else begin
            corr = (r_m >= CORR_MAX) ? $signed(CORR_MAX) : $signed(r_m);
        end
        above      = !r_flat && (corr > i_threshold);
        match_dist = r_start - r_last;
        fresh      = above && (match_dist > POSITION_BITS'(i_min_gap));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:   if (i_job_vld) n_state = BS_MAC;
            BS_MAC:    if ((r_cnt == r_len) && !r_rd_vld) n_state = BS_PROD;
            BS_PROD:   n_state = BS_DIFF;
            BS_DIFF:   n_state = BS_CHECK;
            BS_CHECK:  n_state = ((r_tl == '0) || (r_wl == '0)) ? BS_DONE : BS_MUL;
            BS_MUL:    if (r_step == STEP_W'(V_W - 1)) n_state = BS_ROOT_A;
            BS_ROOT_A: n_state = BS_ROOT_B;
            BS_ROOT_B: n_state = (r_bit == '0) ? BS_DONE : BS_ROOT_A;
            BS_DONE:   if (!i_res_full) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_job_take        = (r_state == BS_IDLE) && i_job_vld;
        o_busy            = (r_state != BS_IDLE);
        o_t_raddr         = r_cnt[AW-1:0];
        o_w_raddr         = r_widx;
        o_res_push        = (r_state == BS_DONE) && !i_res_full;
        o_window_start    = r_start;
        o_correlation     = corr;
        o_above_threshold = above;
        o_new_event       = fresh;
        o_event_count     = fresh ? r_events + EVT_W'(1) : r_events;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_last   <= '0;
            r_events <= '0;
        end else begin
            r_state <= n_state;
            if (o_res_push) begin
                if (above) begin
                    r_last <= r_start;
                end
                if (fresh) begin
                    r_events <= r_events + EVT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                r_len    <= i_job_len;
                r_widx   <= i_job_widx;
                r_start  <= i_job_start;
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
                r_st     <= '0;
                r_sw     <= '0;
                r_stt    <= '0;
                r_sww    <= '0;
                r_stw    <= '0;
            end
            BS_MAC: begin
                if (r_rd_vld) begin
                    r_st  <= r_st + SUM_W'(i_t_rdata);
                    r_sw  <= r_sw + SUM_W'(i_w_rdata);
                    r_stt <= r_stt + SQ_W'(tt);
                    r_sww <= r_sww + SQ_W'(ww);
                    r_stw <= r_stw + SQ_W'(tw);
                end
                if (r_cnt < r_len) begin
                    r_cnt    <= r_cnt + LEN_W'(1);
                    r_widx   <= (r_widx == AW'(TEMPLATE_MAX - 1)) ? '0 : r_widx + AW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            BS_PROD: begin
                r_tl <= len_s * r_stt;
                r_ts <= r_st * r_st;
                r_wl <= len_s * r_sww;
                r_ws <= r_sw * r_sw;
                r_nl <= len_s * r_stw;
                r_ns <= r_st * r_sw;
            end
            BS_DIFF: begin
                r_tl <= r_tl - r_ts;
                r_wl <= r_wl - r_ws;
                r_nl <= r_nl - r_ns;
            end
            BS_CHECK: begin
                r_flat <= (r_tl == '0) || (r_wl == '0);
                r_neg  <= r_nl[V_W-1];
                r_pa   <= WW'($unsigned(r_tl));
                r_pb   <= $unsigned(r_wl);
                r_qa   <= WW'(mag);
                r_qb   <= mag;
                r_prod <= '0;
                r_rsq  <= '0;
                r_step <= '0;
                r_bit  <= BIT_W'(CORR_FRAC);
                r_acc  <= '0;
                r_pm   <= '0;
                r_m    <= '0;
            end
            BS_MUL: begin
                if (r_pb[0]) r_prod <= r_prod + r_pa;
                if (r_qb[0]) r_rsq  <= r_rsq + r_qa;
                r_pa   <= r_pa << 1;
                r_qa   <= r_qa << 1;
                r_pb   <= r_pb >> 1;
                r_qb   <= r_qb >> 1;
                r_step <= r_step + STEP_W'(1);
            end
            BS_ROOT_A: begin
                r_s1 <= r_acc + (r_pm << sh_pm);
            end
            BS_ROOT_B: begin
                if (cand <= rhs) begin
                    r_acc <= cand;
                    r_pm  <= r_pm + (r_prod << r_bit);
                    r_m   <= r_m | (CORR_W'(1) << r_bit);
                end
                if (r_bit != '0) begin
                    r_bit <= r_bit - BIT_W'(1);
                end
            end
            BS_DONE: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_MAC) |-> (r_cnt <= r_len))
        else $error("window index ran past length");

    a_root_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BS_ROOT_B) && (r_bit == '0)) |=> (r_state == BS_DONE))
        else $error("root search did not finish after last bit");

    a_take_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> (r_state == BS_MAC) && (r_cnt == '0) && !r_rd_vld)
        else $error("job taken without starting accumulation");

endmodule

`default_nettype wire

### rtl/core/template_correlation_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// template_correlation_detector_core
// Normalized cross-correlation template matcher with threshold and
// event counting.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     push / full                 i_operation, i_sample
//  result    pop / empty                 o_window_start, o_correlation,
//                                        o_above_threshold, o_new_event,
//                                        o_event_count
//  config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  A template load or a push that yields no result leaves full low.
//  A push that yields a result keeps full high through the serial sum
//  over the window, the bit-serial variance product and the 16-step root
//  search in the back end, and while the result queue is full.
//  A two-entry result queue lets the back end finish while pop is low.
//  Reset clears fill counts, positions and the event counter; stores hold
//  garbage until written.
// ----------------------------------------------------------------------------
module template_correlation_detector_core import tcd_pkg::*; #(
    parameter int TEMPLATE_MAX  = TEMPLATE_MAX_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         i_operation,
    input  wire logic [SAMPLE_BITS-1:0]       i_sample,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [POSITION_BITS-1:0]          o_window_start,
    output logic signed [CORR_W-1:0]          o_correlation,
    output logic                              o_above_threshold,
    output logic                              o_new_event,
    output logic [EVT_W-1:0]                  o_event_count,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW    = (TEMPLATE_MAX > 1) ? $clog2(TEMPLATE_MAX) : 1;
    localparam int LEN_W = $clog2(TEMPLATE_MAX + 1);

    logic [WLEN_W-1:0]         r_wlen;
    logic signed [THR_W-1:0]   r_thr;
    logic [GAP_W-1:0]          r_gap;

    logic                      job_vld, job_take, back_busy;
    logic [LEN_W-1:0]          job_len;
    logic [AW-1:0]             job_widx;
    logic [POSITION_BITS-1:0]  job_start;
    logic                      t_we, w_we;
    logic [AW-1:0]             t_waddr, w_waddr, t_raddr, w_raddr;
    logic [SAMPLE_BITS-1:0]    wdata, t_rdata, w_rdata;

    logic                      res_push;
    logic [POSITION_BITS-1:0]  res_start;
    logic signed [CORR_W-1:0]  res_corr;
    logic                      res_above, res_new;
    logic [EVT_W-1:0]          res_count;

    logic [POSITION_BITS-1:0]  r_f_start [2];
    logic [CORR_W-1:0]         r_f_corr  [2];
    logic                      r_f_above [2];
    logic                      r_f_new   [2];
    logic [EVT_W-1:0]          r_f_count [2];
    logic                      r_wp, r_rp;
    logic [1:0]                r_cnt;
    logic                      res_full;
    logic                      pop_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WINDOW_LENGTH_RST;
            r_thr  <= THRESHOLD_RST;
            r_gap  <= MIN_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_wlen <= i_cfg_data[WLEN_W-1:0];
                CFG_MATCH_THRESH:  r_thr  <= $signed(i_cfg_data[THR_W-1:0]);
                CFG_MIN_GAP:       r_gap  <= i_cfg_data[GAP_W-1:0];
                default:           r_gap  <= r_gap;
            endcase
        end
    end

    assign full = job_vld || back_busy;

    tcd_front #(
        .TEMPLATE_MAX  (TEMPLATE_MAX),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (push && !full),
        .i_operation     (i_operation),
        .i_sample        (i_sample),
        .i_window_length (r_wlen),
        .i_job_take      (job_take),
        .o_job_vld       (job_vld),
        .o_job_len       (job_len),
        .o_job_widx      (job_widx),
        .o_job_start     (job_start),
        .o_t_we          (t_we),
        .o_t_waddr       (t_waddr),
        .o_w_we          (w_we),
        .o_w_waddr       (w_waddr),
        .o_wdata         (wdata)
    );

    tcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TEMPLATE_MAX)
    ) u_template_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    tcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TEMPLATE_MAX)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tcd_back #(
        .TEMPLATE_MAX  (TEMPLATE_MAX),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_threshold       (r_thr),
        .i_min_gap         (r_gap),
        .i_job_vld         (job_vld),
        .o_job_take        (job_take),
        .i_job_len         (job_len),
        .i_job_widx        (job_widx),
        .i_job_start       (job_start),
        .o_busy            (back_busy),
        .o_t_raddr         (t_raddr),
        .o_w_raddr         (w_raddr),
        .i_t_rdata         (t_rdata),
        .i_w_rdata         (w_rdata),
        .o_res_push        (res_push),
        .i_res_full        (res_full),
        .o_window_start    (res_start),
        .o_correlation     (res_corr),
        .o_above_threshold (res_above),
        .o_new_event       (res_new),
        .o_event_count     (res_count)
    );

    assign res_full = (r_cnt == 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign pop_ok   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (res_push) r_wp <= ~r_wp;
            if (pop_ok)   r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, res_push} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_f_start[r_wp] <= res_start;
            r_f_corr[r_wp]  <= res_corr;
            r_f_above[r_wp] <= res_above;
            r_f_new[r_wp]   <= res_new;
            r_f_count[r_wp] <= res_count;
        end
    end

    assign o_window_start    = r_f_start[r_rp];
    assign o_correlation     = $signed(r_f_corr[r_rp]);
    assign o_above_threshold = r_f_above[r_rp];
    assign o_new_event       = r_f_new[r_rp];
    assign o_event_count     = r_f_count[r_rp];

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !res_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result queue count wrong after transfer out");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_full |-> !res_push)
        else $error("result written into a full queue");

    a_full_on_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_vld |-> full)
        else $error("input open while a job waits");

endmodule

`default_nettype wire
